// File: rtl/cdts_pkg.sv
package cdts_pkg;

  // Step request units, coded in req_type[3:1]; req_type[0] selects backward
  typedef enum logic [2:0] {
    U_SEC   = 3'd0,
    U_MIN   = 3'd1,
    U_HOUR  = 3'd2,
    U_DAY   = 3'd3,
    U_MONTH = 3'd4,
    U_YEAR  = 3'd5
  } unit_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_INPUT  = 2'd1,
    ST_YEAR_RANGE = 2'd2
  } status_t;

  // Field limits
  localparam logic [13:0] YEAR_MIN  = 14'd1;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_APR = 4'd4;
  localparam logic [3:0]  MONTH_JUN = 4'd6;
  localparam logic [3:0]  MONTH_SEP = 4'd9;
  localparam logic [3:0]  MONTH_NOV = 4'd11;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [5:0]  SEC_MAX   = 6'd59;

  // Divisibility by 25 via the modular inverse of 25 mod 2^14:
  // y % 25 == 0  <=>  (y * Inv25) mod 2^14 <= floor((2^14 - 1) / 25)
  localparam logic [13:0] INV25      = 14'd7209;
  localparam logic [13:0] DIV25_LIM  = 14'd655;

  // Input transaction payload
  typedef struct packed {
    logic [3:0]  req_type;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
    logic [4:0]  in_hours;
    logic [5:0]  in_minutes;
    logic [5:0]  in_seconds;
  } req_t;

  // Result transaction payload
  typedef struct packed {
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [4:0]  out_hours;
    logic [5:0]  out_minutes;
    logic [5:0]  out_seconds;
    status_t     status;
  } res_t;

  // Gregorian leap year: divisible by 4, centuries only if divisible by 400
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] low;
    logic        div25;
    low   = y * INV25;
    div25 = (low <= DIV25_LIM);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Days in month; months outside 1..12 read as 31
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = 5'd30;
    end else if (m == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end
    return len;
  endfunction

endpackage

// File: rtl/cdts_req_if.sv
interface cdts_req_if;
  logic            valid;
  logic            ready;
  cdts_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cdts_res_if.sv
interface cdts_res_if;
  logic            valid;
  logic            ready;
  cdts_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/calendar_datetime_step_unit.sv
// Gregorian date/time stepper.
// req channel: a date, a time of day and a request to move it one second,
//   minute, hour, day, month or year forward or back (req_type = unit*2+dir).
// res channel: the adjusted date/time with carry/borrow through all fields,
//   day clamped to month end on month and year steps, plus a status:
//   ok, invalid input (input passed through) or year leaving 1..9999
//   (input passed through).
// Each transaction lands in an input register, the whole adjustment is
// computed between that register and the result register, which drives res.
// One transaction per cycle is taken while res does not stall; req.ready
// depends only on whether the input register is empty or can move into
// the result register.
// When res stalls, the result register holds and one more transaction can
// still be taken into the input register; req.ready drops only once both
// registers are full.
// Reset (rst, synchronous) empties both registers; no other state exists.
module calendar_datetime_step_unit (
  input logic       clk,
  input logic       rst,
  cdts_req_if.sink  req,
  cdts_res_if.source res
);
  import cdts_pkg::*;

  logic        s1_valid;
  req_t        s1_data;
  logic        res_valid;
  res_t        res_data;
  logic        s2_free;
  logic        s1_move;
  res_t        calc;

  logic [2:0]  unit;
  logic        back;
  logic [13:0] y;
  logic [13:0] ny;
  logic [3:0]  m;
  logic [4:0]  d;
  logic [4:0]  h;
  logic [5:0]  mi;
  logic [5:0]  s;
  logic        leap_y;
  logic        leap_ny;
  logic        in_ok;
  logic        step_s, step_mi, step_h, step_d, step_mo, step_y;
  logic        wrap_s, wrap_mi, wrap_h, wrap_d, wrap_mo;
  logic [5:0]  s_n;
  logic [5:0]  mi_n;
  logic [4:0]  h_n;
  logic [4:0]  d_n;
  logic [3:0]  mo_n;
  logic [4:0]  lim;
  logic        yr_bad;

  // Handshake: input register moves whenever the result register frees up
  assign s2_free   = !res_valid || res.ready;
  assign s1_move   = s1_valid && s2_free;
  assign req.ready = !s1_valid || s2_free;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_data <= req.data;
    end
  end

  // Calendar adjust
  always_comb begin
    unit = s1_data.req_type[3:1];
    back = s1_data.req_type[0];
    y    = s1_data.in_year;
    m    = s1_data.in_month;
    d    = s1_data.in_day;
    h    = s1_data.in_hours;
    mi   = s1_data.in_minutes;
    s    = s1_data.in_seconds;

    ny      = back ? (y - 14'd1) : (y + 14'd1);
    leap_y  = is_leap(y);
    leap_ny = is_leap(ny);

    in_ok = (y >= YEAR_MIN) && (y <= YEAR_MAX) &&
            (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
            (d >= DAY_FIRST) && (d <= month_len(m, leap_y)) &&
            (h <= HOUR_MAX) && (mi <= MIN_MAX) && (s <= SEC_MAX);

    // carry/borrow chain, seconds up to years
    step_s  = (unit == U_SEC);
    wrap_s  = back ? (s == 6'd0) : (s == SEC_MAX);
    step_mi = (unit == U_MIN) || (step_s && wrap_s);
    wrap_mi = back ? (mi == 6'd0) : (mi == MIN_MAX);
    step_h  = (unit == U_HOUR) || (step_mi && wrap_mi);
    wrap_h  = back ? (h == 5'd0) : (h == HOUR_MAX);
    step_d  = (unit == U_DAY) || (step_h && wrap_h);
    wrap_d  = back ? (d == DAY_FIRST) : (d >= month_len(m, leap_y));
    step_mo = (unit == U_MONTH) || (step_d && wrap_d);
    wrap_mo = back ? (m == MONTH_JAN) : (m == MONTH_DEC);
    step_y  = (unit == U_YEAR) || (step_mo && wrap_mo);

    s_n  = !step_s  ? s  : (wrap_s  ? (back ? SEC_MAX  : 6'd0) :
                                      (back ? s - 6'd1  : s + 6'd1));
    mi_n = !step_mi ? mi : (wrap_mi ? (back ? MIN_MAX  : 6'd0) :
                                      (back ? mi - 6'd1 : mi + 6'd1));
    h_n  = !step_h  ? h  : (wrap_h  ? (back ? HOUR_MAX : 5'd0) :
                                      (back ? h - 5'd1  : h + 5'd1));
    mo_n = !step_mo ? m  : (wrap_mo ? (back ? MONTH_DEC : MONTH_JAN) :
                                      (back ? m - 4'd1  : m + 4'd1));

    // Day: a year change only lands in Jan or Dec except on a year step,
    // so the leap flag of the new year matters for year steps alone
    lim = month_len(mo_n, (unit == U_YEAR) ? leap_ny : leap_y);
    if (step_d) begin
      if (wrap_d) begin
        d_n = back ? lim : DAY_FIRST;
      end else begin
        d_n = back ? (d - 5'd1) : (d + 5'd1);
      end
    end else if (unit == U_MONTH || unit == U_YEAR) begin
      d_n = (d > lim) ? lim : d;
    end else begin
      d_n = d;
    end

    yr_bad = step_y && ((ny < YEAR_MIN) || (ny > YEAR_MAX));

    calc.out_day     = d;
    calc.out_month   = m;
    calc.out_year    = y;
    calc.out_hours   = h;
    calc.out_minutes = mi;
    calc.out_seconds = s;
    calc.status      = ST_OK;
    if (!in_ok) begin
      calc.status = ST_BAD_INPUT;
    end else if (yr_bad) begin
      calc.status = ST_YEAR_RANGE;
    end else begin
      calc.out_day     = d_n;
      calc.out_month   = mo_n;
      calc.out_year    = step_y ? ny : y;
      calc.out_hours   = h_n;
      calc.out_minutes = mi_n;
      calc.out_seconds = s_n;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_free) begin
      res_valid <= s1_valid;
    end
    if (s1_move) begin
      res_data <= calc;
    end
  end

  // Both stages full and output stalled: no new transaction may enter
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res_valid && !res.ready) |-> !req.ready)
    else $error("req accepted while both stages are full");

  // A held transaction in the input register is carried into the result
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> res_valid)
    else $error("input stage moved but result register is empty");

  // Good results stay within calendar ranges
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == ST_OK) |->
      (res_data.out_month >= MONTH_JAN && res_data.out_month <= MONTH_DEC &&
       res_data.out_day >= DAY_FIRST && res_data.out_hours <= HOUR_MAX &&
       res_data.out_minutes <= MIN_MAX && res_data.out_seconds <= SEC_MAX &&
       res_data.out_year >= YEAR_MIN && res_data.out_year <= YEAR_MAX))
    else $error("ok result with a field out of range");

  // Year overflow can only come from the first or the last year
  a_year_edge: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == ST_YEAR_RANGE) |->
      (res_data.out_year == YEAR_MIN || res_data.out_year == YEAR_MAX))
    else $error("year range status on an inner year");

endmodule
